[sv/script_token_classifier_unit_assert.svh]
`ifndef SCRIPT_TOKEN_CLASSIFIER_UNIT_ASSERT_SVH
`define SCRIPT_TOKEN_CLASSIFIER_UNIT_ASSERT_SVH

// Checks that a condition implies another one in the same cycle.
`define STC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("stc assertion failed");

// Checks that a condition implies another one in the following cycle.
`define STC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("stc assertion failed");

`endif

[sv/stc_pkg.sv]
package stc_pkg;

    typedef enum logic [2:0] {
        CLS_INVALID  = 3'd0,
        CLS_NAME     = 3'd1,
        CLS_RAW      = 3'd2,
        CLS_RESERVED = 3'd3,
        CLS_ASSIGN   = 3'd4,
        CLS_OPERATOR = 3'd5,
        CLS_SYMBOL   = 3'd6
    } t_token_class;

    localparam int KW_COUNT  = 10;
    localparam int KW_MAXLEN = 8;

    // Reserved words: release true false func return null else if while delete.
    localparam logic [7:0] KW_TEXT [KW_COUNT][KW_MAXLEN] = '{
        '{"r", "e", "l", "e", "a", "s", "e", 8'h00},
        '{"t", "r", "u", "e", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"f", "a", "l", "s", "e", 8'h00, 8'h00, 8'h00},
        '{"f", "u", "n", "c", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"r", "e", "t", "u", "r", "n", 8'h00, 8'h00},
        '{"n", "u", "l", "l", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"e", "l", "s", "e", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"w", "h", "i", "l", "e", 8'h00, 8'h00, 8'h00},
        '{"d", "e", "l", "e", "t", "e", 8'h00, 8'h00}
    };

    localparam logic [3:0] KW_LEN [KW_COUNT] = '{
        4'd7, 4'd4, 4'd5, 4'd4, 4'd6, 4'd4, 4'd4, 4'd2, 4'd5, 4'd6
    };

    // The words true, false and null are raw values.
    localparam logic [KW_COUNT-1:0] KW_RAW_MASK = 10'h026;

    localparam logic [7:0] CH_DIGIT_LO = 8'd48;
    localparam logic [7:0] CH_DIGIT_HI = 8'd57;
    localparam logic [7:0] CH_UPPER_LO = 8'd65;
    localparam logic [7:0] CH_UPPER_HI = 8'd90;
    localparam logic [7:0] CH_LOWER_LO = 8'd97;
    localparam logic [7:0] CH_LOWER_HI = 8'd122;
    localparam logic [7:0] CH_UNDER    = "_";
    localparam logic [7:0] CH_DOT      = ".";
    localparam logic [7:0] CH_HYPHEN   = "-";
    localparam logic [7:0] CH_QUOTE    = 8'h22;
    localparam logic [7:0] CH_EQUAL    = "=";

    localparam logic [3:0] POS_MAX   = 4'd15;
    localparam logic [1:0] TALLY_MAX = 2'd2;

    typedef struct packed {
        logic alpha;
        logic digit;
        logic under;
        logic op;
        logic sym;
        logic dot;
        logic hyphen;
        logic quote;
        logic equal;
    } t_char_info;

endpackage

[sv/stc_char_decode.sv]
module stc_char_decode
    import stc_pkg::*;
(
    input  logic [7:0] i_char,
    output t_char_info o_info
);

    always_comb begin
        o_info.digit  = (i_char >= CH_DIGIT_LO) && (i_char <= CH_DIGIT_HI);
        o_info.alpha  = ((i_char >= CH_UPPER_LO) && (i_char <= CH_UPPER_HI)) ||
                        ((i_char >= CH_LOWER_LO) && (i_char <= CH_LOWER_HI));
        o_info.under  = (i_char == CH_UNDER);
        o_info.dot    = (i_char == CH_DOT);
        o_info.hyphen = (i_char == CH_HYPHEN);
        o_info.quote  = (i_char == CH_QUOTE);
        o_info.equal  = (i_char == CH_EQUAL);
        o_info.op     = (i_char == "=") || (i_char == "-") || (i_char == "+") ||
                        (i_char == "*") || (i_char == "/") || (i_char == "%") ||
                        (i_char == "&") || (i_char == "|") || (i_char == "!") ||
                        (i_char == "@") || (i_char == "$") || (i_char == ">") ||
                        (i_char == "<");
        o_info.sym    = (i_char == "{") || (i_char == "}") || (i_char == "[") ||
                        (i_char == "]") || (i_char == "(") || (i_char == ")") ||
                        (i_char == ",") || (i_char == ";") || (i_char == ":");
    end

endmodule

[sv/stc_token_tracker.sv]
module stc_token_tracker
    import stc_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_step,
    input  logic [7:0]   i_char,
    input  logic         i_last,
    input  t_char_info   i_info,
    output t_token_class o_class
);

`include "script_token_classifier_unit_assert.svh"

    logic [3:0]          r_char_position;
    logic [KW_COUNT-1:0] r_keyword_hits;
    logic                r_identifier_ok;
    logic                r_all_operator_chars;
    logic [7:0]          r_first_character;
    logic [1:0]          r_dot_tally;
    logic [1:0]          r_hyphen_tally;
    logic                r_digit_seen;
    logic                r_all_numeric_chars;

    logic [KW_COUNT-1:0] n_keyword_hits;
    logic                n_identifier_ok;
    logic                n_all_operator_chars;
    logic [7:0]          n_first_character;
    logic [1:0]          n_dot_tally;
    logic [1:0]          n_hyphen_tally;
    logic                n_digit_seen;
    logic                n_all_numeric_chars;

    logic [2:0] pos_idx;
    logic       pos_first;
    logic       reserved;
    logic       quoted;
    logic       numeric;
    logic       raw;

    assign pos_idx   = r_char_position[2:0];
    assign pos_first = (r_char_position == 4'd0);

    always_comb begin
        for (int k = 0; k < KW_COUNT; k++) begin
            n_keyword_hits[k] = r_keyword_hits[k] &&
                (r_char_position < KW_LEN[k]) &&
                (r_char_position < 4'(KW_MAXLEN)) &&
                (KW_TEXT[k][pos_idx] == i_char) &&
                (!i_last || (({1'b0, r_char_position} + 5'd1) == {1'b0, KW_LEN[k]}));
        end

        if (pos_first) begin
            n_identifier_ok = r_identifier_ok && (i_info.under || i_info.alpha);
        end else begin
            n_identifier_ok = r_identifier_ok &&
                              (i_info.under || i_info.alpha || i_info.digit);
        end

        n_all_operator_chars = r_all_operator_chars && i_info.op;
        n_first_character    = pos_first ? i_char : r_first_character;

        n_dot_tally         = r_dot_tally;
        n_hyphen_tally      = r_hyphen_tally;
        n_digit_seen        = r_digit_seen;
        n_all_numeric_chars = r_all_numeric_chars;
        if (i_info.dot) begin
            if (r_dot_tally < TALLY_MAX) begin
                n_dot_tally = r_dot_tally + 2'd1;
            end
        end else if (i_info.digit) begin
            n_digit_seen = 1'b1;
        end else if (i_info.hyphen && !r_digit_seen && (r_dot_tally == 2'd0)) begin
            if (r_hyphen_tally < TALLY_MAX) begin
                n_hyphen_tally = r_hyphen_tally + 2'd1;
            end
        end else begin
            n_all_numeric_chars = 1'b0;
        end

        reserved = |n_keyword_hits;
        quoted   = !pos_first && (n_first_character == CH_QUOTE) && i_info.quote;
        numeric  = n_all_numeric_chars && n_digit_seen &&
                   (n_dot_tally <= 2'd1) && (n_hyphen_tally <= 2'd1);
        raw      = (|(n_keyword_hits & KW_RAW_MASK)) || quoted || numeric;

        if (n_identifier_ok && !reserved) begin
            o_class = CLS_NAME;
        end else if (raw) begin
            o_class = CLS_RAW;
        end else if (reserved) begin
            o_class = CLS_RESERVED;
        end else if (n_all_operator_chars) begin
            o_class = (pos_first && i_info.equal) ? CLS_ASSIGN : CLS_OPERATOR;
        end else if (pos_first && i_info.sym) begin
            o_class = CLS_SYMBOL;
        end else begin
            o_class = CLS_INVALID;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_last)) begin
            r_char_position      <= 4'd0;
            r_keyword_hits       <= '1;
            r_identifier_ok      <= 1'b1;
            r_all_operator_chars <= 1'b1;
            r_first_character    <= 8'd0;
            r_dot_tally          <= 2'd0;
            r_hyphen_tally       <= 2'd0;
            r_digit_seen         <= 1'b0;
            r_all_numeric_chars  <= 1'b1;
        end else if (i_step) begin
            if (r_char_position < POS_MAX) begin
                r_char_position <= r_char_position + 4'd1;
            end
            r_keyword_hits       <= n_keyword_hits;
            r_identifier_ok      <= n_identifier_ok;
            r_all_operator_chars <= n_all_operator_chars;
            r_first_character    <= n_first_character;
            r_dot_tally          <= n_dot_tally;
            r_hyphen_tally       <= n_hyphen_tally;
            r_digit_seen         <= n_digit_seen;
            r_all_numeric_chars  <= n_all_numeric_chars;
        end
    end

    `STC_ASSERT_NEXT(a_token_restart, i_clk, i_rst_n, i_step && i_last,
                     (r_char_position == 4'd0) && (r_keyword_hits == '1))
    `STC_ASSERT_SAME(a_tally_bound, i_clk, i_rst_n, 1'b1,
                     (r_dot_tally <= TALLY_MAX) && (r_hyphen_tally <= TALLY_MAX))
    `STC_ASSERT_NEXT(a_idle_holds_state, i_clk, i_rst_n, !i_step,
                     $stable(r_char_position) && $stable(r_keyword_hits))

endmodule

[sv/script_token_classifier_unit.sv]
// Token classifier: characters of one token arrive one beat at a time, with
// i_last_char set on the final one, and exactly one class comes out for each
// token, on the beat after its last character has been processed. A new
// character is accepted every clock cycle while the input does not stall; each
// character waits in the input register, where its flags update the running
// token state, and a class waits in the output register until it is taken. The
// last character passes through the input register and its class then through
// the output register; the input stalls only when a last character finds the
// output register full and not being taken.
module script_token_classifier_unit
    import stc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_token_char,
    input  logic       i_last_char,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [2:0] o_token_class
);

`include "script_token_classifier_unit_assert.svh"

    logic         r_in_valid;
    logic [7:0]   r_in_char;
    logic         r_in_last;
    logic         r_out_valid;
    t_token_class r_token_class;

    logic         step;
    t_char_info   info;
    t_token_class token_class;

    assign step    = r_in_valid && (!r_in_last || !r_out_valid || i_ready);
    assign o_ready = !r_in_valid || step;

    stc_char_decode u_decode (
        .i_char (r_in_char),
        .o_info (info)
    );

    stc_token_tracker u_tracker (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_char  (r_in_char),
        .i_last  (r_in_last),
        .i_info  (info),
        .o_class (token_class)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in_char <= i_token_char;
            r_in_last <= i_last_char;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && r_in_last) begin
            r_token_class <= token_class;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_token_class = r_token_class;

    `STC_ASSERT_NEXT(a_last_gives_result, i_clk, i_rst_n, step && r_in_last, r_out_valid)
    `STC_ASSERT_NEXT(a_stalled_char_held, i_clk, i_rst_n, r_in_valid && !step,
                     r_in_valid && $stable(r_in_char) && $stable(r_in_last))
    `STC_ASSERT_SAME(a_class_in_range, i_clk, i_rst_n, r_out_valid,
                     r_token_class <= CLS_SYMBOL)

endmodule
